// ----- rtl/core/scma_pkg.sv -----
// Shared types, constants and helper functions of the seven-channel moving average.
`timescale 1ns / 1ps

package scma_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int NUM_CH      = 7;

	// Width of the window register is fixed by the register map.
	localparam int WIN_W  = 7;
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int CNT_W  = (FILL_W > WIN_W) ? FILL_W : WIN_W;
	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int CH_W   = $clog2(NUM_CH);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int ITER_W = $clog2(SUM_W);

	localparam int RAM_DEPTH = NUM_CH * WINDOW_MAX;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_t;

	typedef struct packed {
		func_t   func;
		sample_t accel_x;
		sample_t accel_y;
		sample_t accel_z;
		sample_t rate_x;
		sample_t rate_y;
		sample_t rate_z;
		sample_t temp_sample;
	} in_item_t;

	typedef struct packed {
		sample_t mean_accel_x;
		sample_t mean_accel_y;
		sample_t mean_accel_z;
		sample_t mean_rate_x;
		sample_t mean_rate_y;
		sample_t mean_rate_z;
		sample_t mean_temp;
	} out_item_t;

	typedef struct packed {
		logic               start;
		sum_t               dividend;
		logic [CNT_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		sample_t quotient;
	} div_rsp_t;

	function automatic sample_vec_t to_vec(in_item_t it);
		sample_vec_t v;
		v[0] = it.accel_x;
		v[1] = it.accel_y;
		v[2] = it.accel_z;
		v[3] = it.rate_x;
		v[4] = it.rate_y;
		v[5] = it.rate_z;
		v[6] = it.temp_sample;
		return v;
	endfunction

	function automatic out_item_t to_out(sample_vec_t v);
		out_item_t o;
		o.mean_accel_x = v[0];
		o.mean_accel_y = v[1];
		o.mean_accel_z = v[2];
		o.mean_rate_x  = v[3];
		o.mean_rate_y  = v[4];
		o.mean_rate_z  = v[5];
		o.mean_temp    = v[6];
		return o;
	endfunction

	function automatic sum_t sext(logic [SAMPLE_BITS-1:0] s);
		return {{(SUM_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
	endfunction

endpackage

// ----- rtl/core/scma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module scma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 448
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/scma_div.sv -----
// Bit-serial signed divider: sum over fill count, truncated toward zero.
`timescale 1ns / 1ps

module scma_div (
	input  logic               clk,
	input  logic               arst_n,
	input  scma_pkg::div_req_t req,
	output scma_pkg::div_rsp_t rsp
);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} div_state_t;

	div_state_t                       state_q;
	logic [scma_pkg::ITER_W-1:0]      cnt_q;
	logic                             neg_q;
	logic [scma_pkg::SUM_W-1:0]       quo_q;
	logic [scma_pkg::CNT_W-1:0]       rem_q;
	logic [scma_pkg::CNT_W-1:0]       den_q;
	logic                             done_q;
	scma_pkg::sample_t                res_q;

	logic [scma_pkg::CNT_W:0]         trial;
	logic                             ge;
	logic [scma_pkg::CNT_W:0]         diff;
	logic [scma_pkg::CNT_W-1:0]       rem_next;
	logic [scma_pkg::SUM_W-1:0]       quo_next;
	logic [scma_pkg::SUM_W-1:0]       quo_signed;
	logic [scma_pkg::SUM_W-1:0]       mag_in;

	// One quotient bit per cycle, restoring form.
	always_comb begin
		trial      = {rem_q, quo_q[scma_pkg::SUM_W-1]};
		ge         = trial >= {1'b0, den_q};
		diff       = trial - {1'b0, den_q};
		rem_next   = ge ? diff[scma_pkg::CNT_W-1:0] : trial[scma_pkg::CNT_W-1:0];
		quo_next   = {quo_q[scma_pkg::SUM_W-2:0], ge};
		quo_signed = neg_q ? (~quo_next + 1'b1) : quo_next;
		mag_in     = req.dividend[scma_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						neg_q   <= req.dividend[scma_pkg::SUM_W-1];
						quo_q   <= mag_in;
						rem_q   <= '0;
						den_q   <= req.divisor;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					quo_q <= quo_next;
					rem_q <= rem_next;
					if (cnt_q == scma_pkg::ITER_W'(scma_pkg::SUM_W - 1)) begin
						res_q   <= quo_signed[scma_pkg::SAMPLE_BITS-1:0];
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;

endmodule

// ----- rtl/core/seven_channel_moving_average.sv -----
// Top level of the seven-channel boxcar moving average with its sequencer.
`timescale 1ns / 1ps
// Usage
// The sample channel (sample_valid, sample_stall, sample) carries one beat per inertial
// sample set: three acceleration axes, three rotation rates and temperature. A beat
// with func set to clear empties the history of all seven channels and yields no result.
// The mean channel (mean_valid, mean_stall, mean) returns one beat of seven windowed
// means, each truncated toward zero, for every sample beat.
// A sample beat is worked one channel at a time: a ring read, a sum update with the
// ring write, then a bit-serial division of the sum by the fill count in one shared
// divider, which takes most of the time per channel. A new beat is taken only once the
// means of the last have been handed to the output register. A window of zero passes
// the samples unaveraged through res_q and the output register, and the next beat is
// taken once they are handed over. A clear beat is worked at once in the idle state.
// sample_stall is high while a beat is being worked and in the cycle of a window write.
// The finished means wait in an output register, so a stalled receiver only holds the
// block once the next result is ready to be handed over.
// Writing window_wdata with window_we sets the window length and, while idle, clears all history.
// Reset restores a window of eight and empty history; the ring needs no clearing pass
// because the fill count keeps unwritten slots out of the sum.

module seven_channel_moving_average (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        window_we,
	input  logic [scma_pkg::WIN_W-1:0]  window_wdata,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  scma_pkg::in_item_t          sample,
	output logic                        mean_valid,
	input  logic                        mean_stall,
	output scma_pkg::out_item_t         mean
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_UPDATE,
		S_DIVIDE,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [scma_pkg::WIN_W-1:0]        window_q;
	logic [scma_pkg::CNT_W-1:0]        fill_q;
	logic [scma_pkg::SLOT_W-1:0]       wslot_q;
	logic [scma_pkg::SLOT_W-1:0]       slot_q;
	logic                              full_q;
	logic [scma_pkg::CNT_W-1:0]        divisor_q;
	logic [scma_pkg::CH_W-1:0]         ch_q;
	scma_pkg::sample_vec_t             in_q;
	scma_pkg::sample_vec_t             res_q;
	scma_pkg::sum_t                    sum_q [scma_pkg::NUM_CH];
	logic                              out_valid_q;
	scma_pkg::out_item_t               out_q;

	logic [scma_pkg::CNT_W-1:0]        win_eff;
	logic                              win_full;
	logic [scma_pkg::SLOT_W-1:0]       slot_use;
	logic [scma_pkg::SLOT_W-1:0]       slot_inc;
	logic [scma_pkg::SLOT_W-1:0]       slot_next;
	logic                              fill_full;
	scma_pkg::sum_t                    new_sum;
	logic [scma_pkg::RAM_AW-1:0]       ram_addr;
	logic [scma_pkg::SAMPLE_BITS-1:0]  ram_rdata;
	logic                              out_free;
	scma_pkg::div_req_t                div_req;
	scma_pkg::div_rsp_t                div_rsp;

	always_comb begin
		// Windows above the ring depth saturate at the ring depth.
		win_full  = scma_pkg::CNT_W'(window_q) > scma_pkg::CNT_W'(scma_pkg::WINDOW_MAX);
		win_eff   = win_full ? scma_pkg::CNT_W'(scma_pkg::WINDOW_MAX)
		                     : scma_pkg::CNT_W'(window_q);
		slot_use  = (scma_pkg::CNT_W'(wslot_q) >= win_eff) ? '0 : wslot_q;
		slot_inc  = slot_use + 1'b1;
		slot_next = ((scma_pkg::CNT_W'(slot_use) + 1'b1) == win_eff) ? '0 : slot_inc;
		fill_full = fill_q >= win_eff;

		// Once the window is full the oldest sample leaves the sum.
		new_sum = sum_q[ch_q] + scma_pkg::sext(in_q[ch_q])
		        - (full_q ? scma_pkg::sext(ram_rdata) : '0);

		ram_addr = scma_pkg::RAM_AW'(ch_q) * scma_pkg::RAM_AW'(scma_pkg::WINDOW_MAX)
		         + scma_pkg::RAM_AW'(slot_q);

		div_req.start    = (state_q == S_UPDATE);
		div_req.dividend = new_sum;
		div_req.divisor  = divisor_q;

		out_free = !out_valid_q || !mean_stall;
	end

	scma_ram #(
		.WIDTH (scma_pkg::SAMPLE_BITS),
		.DEPTH (scma_pkg::RAM_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_UPDATE),
		.waddr (ram_addr),
		.wdata (in_q[ch_q]),
		.re    (state_q == S_READ),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	scma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= scma_pkg::WINDOW_RESET;
			fill_q      <= '0;
			wslot_q     <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			divisor_q   <= '0;
			ch_q        <= '0;
			in_q        <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < scma_pkg::NUM_CH; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			// In S_DONE a free output register is reloaded in the same cycle instead.
			if (out_valid_q && !mean_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					// A window write empties the history; the user must issue it only while idle (the block
					// itself does not enforce this), and the sample channel is stalled in that cycle.
					if (window_we) begin
						fill_q  <= '0;
						wslot_q <= '0;
						for (int i = 0; i < scma_pkg::NUM_CH; i++) begin
							sum_q[i] <= '0;
						end
					end else if (sample_valid) begin
						if (sample.func == scma_pkg::FUNC_CLEAR) begin
							fill_q  <= '0;
							wslot_q <= '0;
							for (int i = 0; i < scma_pkg::NUM_CH; i++) begin
								sum_q[i] <= '0;
							end
						end else if (win_eff == '0) begin
							res_q   <= scma_pkg::to_vec(sample);
							state_q <= S_DONE;
						end else begin
							in_q      <= scma_pkg::to_vec(sample);
							slot_q    <= slot_use;
							wslot_q   <= slot_next;
							full_q    <= fill_full;
							divisor_q <= fill_full ? fill_q : fill_q + 1'b1;
							fill_q    <= fill_full ? fill_q : fill_q + 1'b1;
							ch_q      <= '0;
							state_q   <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					sum_q[ch_q] <= new_sum;
					state_q     <= S_DIVIDE;
				end
				S_DIVIDE: begin
					if (div_rsp.done) begin
						res_q[ch_q] <= div_rsp.quotient;
						if (ch_q == scma_pkg::CH_W'(scma_pkg::NUM_CH - 1)) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q       <= scma_pkg::to_out(res_q);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (window_we) begin
				window_q <= window_wdata;
			end
		end
	end

	assign sample_stall = (state_q != S_IDLE) || window_we;
	assign mean_valid   = out_valid_q;
	assign mean         = out_q;

endmodule
